### design/sorted_array_table_top_macros.svh
// assertion macros for the sorted array table
`ifndef SORTED_ARRAY_TABLE_TOP_MACROS_SVH
`define SORTED_ARRAY_TABLE_TOP_MACROS_SVH

// check that holds in the same cycle as the antecedent
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that holds in the cycle after the antecedent
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sat_pkg.sv
// shared types and constants for the sorted array table
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

	localparam int KEY_W = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;
	localparam int OP_W = 2;
	localparam int ST_W = 2;
	localparam int IDX_SPAN = 1 << IDX_W;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 48;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
		logic clr;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} sat_cmd_t;

endpackage

`default_nettype wire

### design/sat_cell.sv
// one slot of the key row: compare against the new key and shift
`timescale 1ns / 1ps
`default_nettype none

module sat_cell #(
	parameter int POS = 0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sat_pkg::sat_cmd_t         cmd,
	input  wire logic                      valid,
	input  wire logic                      left_lt,
	input  wire logic [sat_pkg::KEY_W-1:0] left_key,
	input  wire logic [sat_pkg::KEY_W-1:0] right_key,
	output logic                           lt,
	output logic [sat_pkg::KEY_W-1:0]      key_q
);

	localparam int PIDX = POS % sat_pkg::IDX_SPAN;
	localparam logic [sat_pkg::IDX_W-1:0] POS_IDX = PIDX[sat_pkg::IDX_W-1:0];

	logic rem_here;

	// slot lies at or above the removed index
	if (POS >= sat_pkg::IDX_SPAN) begin : g_far
		assign rem_here = 1'b1;
	end else begin : g_near
		assign rem_here = (POS_IDX >= cmd.idx);
	end

	// held key is valid and sorts strictly below the incoming key
	assign lt = valid && (key_q < cmd.key);

	// slot update: clear, keep, take new key, shift up or shift down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else begin
			priority if (cmd.clr) begin
				key_q <= '0;
			end else if (cmd.ins) begin
				if (!lt) begin
					key_q <= left_lt ? cmd.key : left_key;
				end
			end else if (cmd.rem && rem_here) begin
				key_q <= right_key;
			end else begin
				key_q <= key_q;
			end
		end
	end

endmodule

`default_nettype wire

### design/sat_read.sv
// index read-out and insert position encoder over the key row
`timescale 1ns / 1ps
`default_nettype none

module sat_read #(
	parameter int DEPTH = 32
) (
	input  wire logic [DEPTH-1:0]          lt,
	input  wire logic [sat_pkg::KEY_W-1:0] keys [DEPTH],
	input  wire logic [sat_pkg::IDX_W-1:0] idx,
	output logic [sat_pkg::KEY_W-1:0]      rd_key,
	output logic [sat_pkg::IDX_W-1:0]      pos
);

	localparam int RD_N = (DEPTH < sat_pkg::IDX_SPAN) ? DEPTH : sat_pkg::IDX_SPAN;

	// only the slots an index can name take part in the read
	always_comb begin
		rd_key = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (idx == i[sat_pkg::IDX_W-1:0]) begin
				rd_key = keys[i];
			end
		end
	end

	// the sorted row gives a single edge where the less-than run ends
	always_comb begin
		pos = '0;
		for (int i = 1; i < DEPTH; i++) begin
			if (lt[i-1] && !lt[i]) begin
				pos = pos | i[sat_pkg::IDX_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

### design/sorted_array_table_top.sv
// the result item is registered as the item is accepted
// throughput: one item per cycle while the result side keeps taking items
// the figure is set by the cell row, which compares and shifts all slots at once
// reset: count cleared, all slots zero, capacity limit back to 32, no result pending
// top level of the sorted array table
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_array_table_top_macros.svh"

module sorted_array_table_top #(
	parameter int DEPTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// key [31:0], index [36:32], zero fill
	input  wire logic [sat_pkg::IN_TDATA_W-1:0]  s_tdata,
	// op [1:0]
	input  wire logic [sat_pkg::OP_W-1:0]        s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// value [31:0], position [36:32], count [42:37], zero fill
	output logic [sat_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// status [1:0]
	output logic [sat_pkg::ST_W-1:0]             m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sat_pkg::CNT_W-1:0]       cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > sat_pkg::CNT_W) ? CW : sat_pkg::CNT_W;

	logic [CW-1:0]                count_q;
	logic [sat_pkg::CNT_W-1:0]    cap_q;
	logic                         m_tvalid_q;
	logic [sat_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic [sat_pkg::ST_W-1:0]     m_tuser_q;

	logic [sat_pkg::OP_W-1:0]     op;
	logic [sat_pkg::KEY_W-1:0]    key;
	logic [sat_pkg::IDX_W-1:0]    idx;
	logic                         acc;
	logic [MW-1:0]                cap_w;
	logic [MW-1:0]                depth_w;
	logic [MW-1:0]                lim;
	logic [MW-1:0]                count_w;
	logic [MW-1:0]                idx_w;
	logic                         full;
	logic                         oor;
	sat_pkg::sat_cmd_t            cmd;

	logic [DEPTH-1:0]             valid;
	logic [DEPTH-1:0]             lt;
	logic [sat_pkg::KEY_W-1:0]    keys [DEPTH];
	logic [sat_pkg::KEY_W-1:0]    rd_key;
	logic [sat_pkg::IDX_W-1:0]    pos;

	logic [CW-1:0]                cnt_nx;
	logic [MW-1:0]                cnt_nx_w;
	logic [sat_pkg::KEY_W-1:0]    res_value;
	logic [sat_pkg::IDX_W-1:0]    res_pos;
	logic [sat_pkg::ST_W-1:0]     res_status;

	// input fields
	assign op  = s_tuser;
	assign key = s_tdata[31:0];
	assign idx = s_tdata[36:32];

	// handshakes: output register frees the input side
	assign s_tready  = !m_tvalid_q || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// limit in use and rejection checks
	assign cap_w   = MW'(cap_q);
	assign depth_w = MW'(DEPTH);
	assign lim     = (cap_w > depth_w) ? depth_w : cap_w;
	assign count_w = MW'(count_q);
	assign idx_w   = MW'(idx);
	assign full    = (count_w >= lim);
	assign oor     = (idx_w >= count_w);

	// command to the cell row
	assign cmd.ins = acc && (op == sat_pkg::OP_INSERT) && !full;
	assign cmd.rem = acc && (op == sat_pkg::OP_REMOVE) && !oor;
	assign cmd.clr = acc && (op == sat_pkg::OP_CLEAR);
	assign cmd.key = key;
	assign cmd.idx = idx;

	// row of cells, each linked to its neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      left_lt;
		logic [sat_pkg::KEY_W-1:0] left_key;
		logic [sat_pkg::KEY_W-1:0] right_key;

		assign valid[i] = (MW'(i) < count_w);

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_key = '0;
		end else begin : g_mid
			assign left_lt  = lt[i-1];
			assign left_key = keys[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_key = '0;
		end else begin : g_inner
			assign right_key = keys[i+1];
		end

		sat_cell #(
			.POS(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.valid    (valid[i]),
			.left_lt  (left_lt),
			.left_key (left_key),
			.right_key(right_key),
			.lt       (lt[i]),
			.key_q    (keys[i])
		);
	end

	sat_read #(
		.DEPTH(DEPTH)
	) u_read (
		.lt    (lt),
		.keys  (keys),
		.idx   (idx),
		.rd_key(rd_key),
		.pos   (pos)
	);

	// count after this item
	always_comb begin
		priority if (cmd.clr) begin
			cnt_nx = '0;
		end else if (cmd.ins) begin
			cnt_nx = CW'(count_q + 1'b1);
		end else if (cmd.rem) begin
			cnt_nx = CW'(count_q - 1'b1);
		end else begin
			cnt_nx = count_q;
		end
	end
	assign cnt_nx_w = MW'(cnt_nx);

	// result fields
	always_comb begin
		res_value  = '0;
		res_pos    = '0;
		res_status = sat_pkg::ST_OK;
		unique case (op)
			sat_pkg::OP_INSERT: begin
				if (full) begin
					res_status = sat_pkg::ST_FULL;
				end else begin
					res_pos = pos;
				end
			end
			sat_pkg::OP_LOOKUP, sat_pkg::OP_REMOVE: begin
				if (oor) begin
					res_status = sat_pkg::ST_RANGE;
				end else begin
					res_value = rd_key;
				end
			end
			sat_pkg::OP_CLEAR: begin
				res_status = sat_pkg::ST_OK;
			end
			default: begin
				res_status = sat_pkg::ST_OK;
			end
		endcase
	end

	// count and capacity limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= sat_pkg::CNT_W'(32);
		end else begin
			count_q <= cnt_nx;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (acc) begin
			m_tdata_q <= {5'd0, cnt_nx_w[sat_pkg::CNT_W-1:0], res_pos, res_value};
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks on the count and the result register
	`SAT_ASSERT_NEXT(a_ins_count, cmd.ins, count_q == $past(count_q) + 1'b1, "insert count")
	`SAT_ASSERT_NEXT(a_clr_count, cmd.clr, (count_q == '0) && m_tvalid, "clear count")
	`SAT_ASSERT_NOW(a_ins_room, cmd.ins, count_w < lim, "insert past limit")
	`SAT_ASSERT_NEXT(a_acc_result, acc, m_tvalid, "result missing")

endmodule

`default_nettype wire
